@@ rtl/sfd_pkg.sv @@
// Shared types and constants for the SLIP frame decoder.
// No dependencies; used by slip_frame_decoder.
package sfd_pkg;

    localparam int unsigned MAX_FRAME_LIMIT = 4096;
    localparam int unsigned COUNT_W         = 13;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned TDATA_W         = 24;
    localparam int unsigned PADDR_W         = 5;

    localparam logic [COUNT_W-1:0] LIMIT_MAX  = COUNT_W'(MAX_FRAME_LIMIT);
    localparam logic [COUNT_W-1:0] LIMIT_MIN  = COUNT_W'(1);

    // Register reset values (standard SLIP codes).
    localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = COUNT_W'(4096);
    localparam logic [BYTE_W-1:0]  END_RESET       = 8'hC0;
    localparam logic [BYTE_W-1:0]  ESC_RESET       = 8'hDB;
    localparam logic [BYTE_W-1:0]  ESC_END_RESET   = 8'hDC;
    localparam logic [BYTE_W-1:0]  ESC_ESC_RESET   = 8'hDD;

    typedef enum logic [2:0] {
        REG_MAX_FRAME = 3'd0,
        REG_END       = 3'd1,
        REG_ESC       = 3'd2,
        REG_ESC_END   = 3'd3,
        REG_ESC_ESC   = 3'd4
    } reg_index_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_CLOSE   = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t        kind;
        logic [BYTE_W-1:0]   payload;
        logic [COUNT_W-1:0]  length;
        logic                last;
    } result_t;

endpackage

@@ rtl/slip_frame_decoder.sv @@
// SLIP receive-side frame decoder: top level with APB register file,
// per-byte decode logic and an output register with a skid stage. Uses sfd_pkg.
//
// Usage: raw serial bytes enter on the s_axis channel, one word per byte.
// Bytes seen before a start END are dropped. Each decoded payload byte
// leaves on m_axis with tuser = 0, tdata holding the byte and the running
// count, and tlast set when the byte reaches the configured frame limit.
// An END closing a non-empty frame gives a word with tuser = 1, a zero
// payload byte, the frame length and tlast = 1. Other bytes give no word.
// A decoded result is registered before it shows on m_axis_tvalid, and one
// byte is accepted every cycle while the output drains; the decode of a
// byte is a single pass of comparators and one 13-bit increment.
// When the receiver stalls, one result waits in the output register and a
// second in the skid stage; s_axis_tready falls only once the skid stage
// is occupied. Reset clears the frame state, empties both stages and restores
// the standard SLIP codes and a 4096-byte limit. The user must write registers
// over APB only while the stream is idle; the block does not enforce this.
module slip_frame_decoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Received bytes
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] rx_byte
    // Decoded results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sfd_pkg::TDATA_W-1:0]        m_axis_tdata,   // [7:0] payload_byte,
                                                               // [20:8] frame_length,
                                                               // [23:21] zero
    output logic                               m_axis_tuser,   // [0] result_kind
    output logic                               m_axis_tlast    // frame_last
);

    logic [sfd_pkg::COUNT_W-1:0] max_frame_reg;
    logic [7:0]                  end_code_reg;
    logic [7:0]                  esc_code_reg;
    logic [7:0]                  esc_end_reg;
    logic [7:0]                  esc_esc_reg;

    logic                        frame_open_reg, frame_open_next;
    logic                        esc_pending_reg, esc_pending_next;
    logic [sfd_pkg::COUNT_W-1:0] count_reg, count_next;

    sfd_pkg::result_t            out_reg, skid_reg, result;
    logic                        out_valid_reg, skid_valid_reg;
    logic                        result_valid;

    logic                        cfg_write;
    sfd_pkg::reg_index_t         cfg_index;
    logic                        in_accept, out_take;
    logic [sfd_pkg::COUNT_W-1:0] limit;
    logic [sfd_pkg::COUNT_W-1:0] count_inc;
    logic [7:0]                  data_byte;
    logic                        store;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = sfd_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= sfd_pkg::MAX_FRAME_RESET;
            end_code_reg  <= sfd_pkg::END_RESET;
            esc_code_reg  <= sfd_pkg::ESC_RESET;
            esc_end_reg   <= sfd_pkg::ESC_END_RESET;
            esc_esc_reg   <= sfd_pkg::ESC_ESC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sfd_pkg::REG_MAX_FRAME: max_frame_reg <= pwdata[sfd_pkg::COUNT_W-1:0];
                sfd_pkg::REG_END:       end_code_reg  <= pwdata[7:0];
                sfd_pkg::REG_ESC:       esc_code_reg  <= pwdata[7:0];
                sfd_pkg::REG_ESC_END:   esc_end_reg   <= pwdata[7:0];
                sfd_pkg::REG_ESC_ESC:   esc_esc_reg   <= pwdata[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            sfd_pkg::REG_MAX_FRAME: prdata = 32'(max_frame_reg);
            sfd_pkg::REG_END:       prdata = 32'(end_code_reg);
            sfd_pkg::REG_ESC:       prdata = 32'(esc_code_reg);
            sfd_pkg::REG_ESC_END:   prdata = 32'(esc_end_reg);
            sfd_pkg::REG_ESC_ESC:   prdata = 32'(esc_esc_reg);
            default:                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (max_frame_reg == '0)
            limit = sfd_pkg::LIMIT_MIN;
        else if (max_frame_reg > sfd_pkg::LIMIT_MAX)
            limit = sfd_pkg::LIMIT_MAX;
        else
            limit = max_frame_reg;
    end

    assign count_inc = count_reg + sfd_pkg::COUNT_W'(1);

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        esc_pending_next = esc_pending_reg;
        count_next       = count_reg;
        result_valid     = 1'b0;
        result           = '0;
        data_byte        = s_axis_tdata;
        store            = 1'b0;

        if (esc_pending_reg)
        begin
            // The byte after an escape is never a delimiter.
            esc_pending_next = 1'b0;
            store            = 1'b1;
            if (s_axis_tdata == esc_end_reg)
                data_byte = end_code_reg;
            else if (s_axis_tdata == esc_esc_reg)
                data_byte = esc_code_reg;
        end
        else if (s_axis_tdata == end_code_reg)
        begin
            if (frame_open_reg && count_reg != '0)
            begin
                result_valid    = 1'b1;
                result.kind     = sfd_pkg::KIND_CLOSE;
                result.length   = count_reg;
                result.last     = 1'b1;
                frame_open_next = 1'b0;
                count_next      = '0;
            end
            else
            begin
                frame_open_next = 1'b1;
            end
        end
        else if (s_axis_tdata == esc_code_reg)
        begin
            esc_pending_next = 1'b1;
        end
        else
        begin
            store = 1'b1;
        end

        if (store && frame_open_reg)
        begin
            result_valid   = 1'b1;
            result.kind    = sfd_pkg::KIND_PAYLOAD;
            result.payload = data_byte;
            result.length  = count_inc;
            if (count_inc >= limit)
            begin
                result.last     = 1'b1;
                frame_open_next = 1'b0;
                count_next      = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            esc_pending_reg <= 1'b0;
            count_reg       <= '0;
        end
        else if (in_accept)
        begin
            frame_open_reg  <= frame_open_next;
            esc_pending_reg <= esc_pending_next;
            count_reg       <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    assign out_take = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Input is held off; drain the skid stage first.
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (in_accept && result_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (in_accept && result_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= result;
            else
                skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.length, out_reg.payload};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    a_closed_has_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> count_reg == '0)
        else $error("byte count not cleared while no frame is open");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sfd_pkg::LIMIT_MAX)
        else $error("byte count beyond the frame limit");

    a_close_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == sfd_pkg::KIND_CLOSE)
            |-> (out_reg.last && out_reg.payload == '0 && out_reg.length != '0))
        else $error("frame close word malformed");

endmodule
